[rtl/core/kta_pkg.sv]
`default_nettype none
package kta_pkg;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_OBSERVE = 2'd0,
    MODE_PRUNE   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_PRUNED   = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PRUNE_RD,
    S_PRUNE_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_READ_RD,
    S_READ_OUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] kind;
    logic [31:0] position;
    logic [31:0] health;
    logic [31:0] shield;
    logic [1:0]  flags;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic   [1:0]  mode;
    logic   [63:0] key;
    logic   [31:0] now;
    logic   [5:0]  slot_index;
    logic   [15:0] kind;
    logic   [31:0] position;
    logic   [31:0] health;
    logic   [31:0] shield;
    logic   [1:0]  flags;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [6:0]  entry_count;
    logic [6:0]  removed_count;
    logic [63:0] out_key;
    logic [15:0] out_kind;
    logic [31:0] out_position;
    logic [31:0] out_health;
    logic [31:0] out_shield;
    logic [1:0]  out_flags;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
  } rsp_t;
endpackage
`default_nettype wire

[rtl/core/kta_if.sv]
`default_nettype none
interface kta_req_if;
  logic            valid;
  logic            ready;
  kta_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kta_rsp_if;
  logic            valid;
  logic            ready;
  kta_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kta_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/kta_ram.sv]
`default_nettype none
module kta_ram (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [kta_pkg::AW-1:0] waddr,
  input  wire kta_pkg::entry_t        wdata,
  input  wire logic [kta_pkg::AW-1:0] raddr,
  output kta_pkg::entry_t             rdata
);
  kta_pkg::entry_t mem [kta_pkg::DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/keyed_table_with_aging.sv]
// Keyed table with aging: up to 64 entries keyed by a 64-bit tag, held in one
// memory with a single registered read port. One request is worked at a time;
// ready drops until its response is taken. Observe scans filled slots in turn,
// reading each and then comparing its key. Prune walks slots in the same way
// and, for each removed entry, moves the last entry down into its slot (read,
// then write). The age limit register is written through its own channel while
// the block is idle.
`default_nettype none
module keyed_table_with_aging (
  input  wire logic  clk,
  input  wire logic  rst,
  kta_req_if.sink    req,
  kta_rsp_if.source  rsp,
  kta_cfg_if.sink    cfg
);
  localparam int unsigned AW = kta_pkg::AW;
  localparam int unsigned CW = kta_pkg::CW;

  kta_pkg::state_t state, state_next;
  kta_pkg::req_t   cur;
  kta_pkg::rsp_t   res;
  logic [31:0]     age_limit;
  logic [CW-1:0]   fill_count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   removed;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  kta_pkg::entry_t wdata, rdata;

  logic            scan_end, key_hit, stale;
  logic [32:0]     limit;

  kta_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == kta_pkg::S_IDLE);
  assign cfg.ready = (state == kta_pkg::S_IDLE);
  assign rsp.valid = (state == kta_pkg::S_DONE);
  assign rsp.data  = res;

  assign scan_end = (idx >= fill_count);
  assign key_hit  = (rdata.key == cur.key);
  assign limit    = {1'b0, rdata.last_seen} + {1'b0, age_limit};
  assign stale    = (limit < {1'b0, cur.now});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kta_pkg::S_IDLE: begin
        if (req.valid) begin
          unique case (kta_pkg::mode_t'(req.data.mode))
            kta_pkg::MODE_OBSERVE: state_next = kta_pkg::S_SCAN_RD;
            kta_pkg::MODE_PRUNE:   state_next = kta_pkg::S_PRUNE_RD;
            kta_pkg::MODE_READ:    state_next = kta_pkg::S_READ_RD;
            default:               state_next = kta_pkg::S_DONE;
          endcase
        end
      end
      kta_pkg::S_SCAN_RD:   state_next = scan_end ? kta_pkg::S_DONE : kta_pkg::S_SCAN_CHK;
      kta_pkg::S_SCAN_CHK:  state_next = key_hit ? kta_pkg::S_DONE : kta_pkg::S_SCAN_RD;
      kta_pkg::S_PRUNE_RD:  state_next = scan_end ? kta_pkg::S_DONE : kta_pkg::S_PRUNE_CHK;
      kta_pkg::S_PRUNE_CHK: state_next = stale ? kta_pkg::S_MOVE_RD : kta_pkg::S_PRUNE_RD;
      kta_pkg::S_MOVE_RD:   state_next = kta_pkg::S_MOVE_WR;
      kta_pkg::S_MOVE_WR:   state_next = kta_pkg::S_PRUNE_RD;
      kta_pkg::S_READ_RD:   state_next = kta_pkg::S_READ_OUT;
      kta_pkg::S_READ_OUT:  state_next = kta_pkg::S_DONE;
      kta_pkg::S_DONE:      state_next = rsp.ready ? kta_pkg::S_IDLE : kta_pkg::S_DONE;
      default:              state_next = kta_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    raddr = idx[AW-1:0];
    wdata = rdata;
    wdata.kind     = cur.kind;
    wdata.position = cur.position;
    wdata.health   = cur.health;
    wdata.shield   = cur.shield;
    wdata.flags    = cur.flags;
    wdata.last_seen = cur.now;
    unique case (state)
      kta_pkg::S_SCAN_RD: begin
        if (scan_end && (fill_count < CW'(kta_pkg::DEPTH))) begin
          we = 1'b1;
          wdata.key        = cur.key;
          wdata.first_seen = cur.now;
        end
      end
      kta_pkg::S_SCAN_CHK: begin
        we = key_hit;
      end
      kta_pkg::S_MOVE_RD: begin
        raddr = AW'(fill_count - CW'(1));
      end
      kta_pkg::S_MOVE_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      kta_pkg::S_READ_RD: begin
        raddr = cur.slot_index[AW-1:0];
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kta_pkg::S_IDLE;
      fill_count <= '0;
      age_limit  <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        age_limit <= cfg.data;
      end
      unique case (state)
        kta_pkg::S_IDLE: begin
          if (req.valid) begin
            cur     <= req.data;
            idx     <= '0;
            removed <= '0;
            if (kta_pkg::mode_t'(req.data.mode) == kta_pkg::MODE_CLEAR) begin
              fill_count <= '0;
              res        <= '{status: kta_pkg::ST_CLEARED, default: '0};
            end else begin
              res <= '0;
            end
          end
        end
        kta_pkg::S_SCAN_RD: begin
          if (scan_end) begin
            if (fill_count < CW'(kta_pkg::DEPTH)) begin
              res.status <= kta_pkg::ST_INSERTED;
              res.slot   <= 6'(fill_count);
              fill_count <= fill_count + CW'(1);
              res.entry_count <= 7'(fill_count + CW'(1));
            end else begin
              res.status      <= kta_pkg::ST_FULL;
              res.entry_count <= 7'(fill_count);
            end
          end
        end
        kta_pkg::S_SCAN_CHK: begin
          if (key_hit) begin
            res.status      <= kta_pkg::ST_UPDATED;
            res.slot        <= 6'(idx);
            res.entry_count <= 7'(fill_count);
          end else begin
            idx <= idx + CW'(1);
          end
        end
        kta_pkg::S_PRUNE_RD: begin
          if (scan_end) begin
            res.status        <= kta_pkg::ST_PRUNED;
            res.entry_count   <= 7'(fill_count);
            res.removed_count <= 7'(removed);
          end
        end
        kta_pkg::S_PRUNE_CHK: begin
          if (!stale) begin
            idx <= idx + CW'(1);
          end
        end
        kta_pkg::S_MOVE_WR: begin
          fill_count <= fill_count - CW'(1);
          removed    <= removed + CW'(1);
        end
        kta_pkg::S_READ_OUT: begin
          res.slot        <= cur.slot_index;
          res.entry_count <= 7'(fill_count);
          if (CW'(cur.slot_index) < fill_count) begin
            res.status       <= kta_pkg::ST_READ_OK;
            res.out_key      <= rdata.key;
            res.out_kind     <= rdata.kind;
            res.out_position <= rdata.position;
            res.out_health   <= rdata.health;
            res.out_shield   <= rdata.shield;
            res.out_flags    <= rdata.flags;
            res.first_seen   <= rdata.first_seen;
            res.last_seen    <= rdata.last_seen;
          end else begin
            res.status <= kta_pkg::ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(kta_pkg::DEPTH)) else $error("fill count above depth");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != kta_pkg::S_IDLE |-> !req.ready) else $error("ready while busy");
  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == kta_pkg::S_MOVE_WR |=> fill_count == $past(fill_count) - CW'(1))
    else $error("prune move did not shrink table");
`endif
endmodule
`default_nettype wire

[tb/kta_tb_checker.sv]
`default_nettype none
module kta_tb_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_ready,
  input  wire kta_pkg::req_t req_data,
  input  wire logic          rsp_valid,
  input  wire logic          rsp_ready,
  input  wire kta_pkg::rsp_t rsp_data,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic [31:0]   cfg_data,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  kta_pkg::entry_t table_mem [kta_pkg::DEPTH];
  int unsigned     table_fill;
  logic [31:0]     stale_limit;
  kta_pkg::rsp_t   expected_rsp_q[$];

  assign pending_count = expected_rsp_q.size();

  // work out the response a request should produce and update the table copy
  function automatic kta_pkg::rsp_t table_apply(kta_pkg::req_t r);
    kta_pkg::rsp_t o;
    int     i;
    bit     hit;
    logic [32:0] deadline;
    o = '0;
    hit = 0;
    case (kta_pkg::mode_t'(r.mode))
      kta_pkg::MODE_OBSERVE: begin
        for (i = 0; i < table_fill; i++) begin
          if (table_mem[i].key == r.key) begin
            hit = 1;
            break;
          end
        end
        if (hit) begin
          table_mem[i].kind = r.kind;
          table_mem[i].position = r.position;
          table_mem[i].health = r.health;
          table_mem[i].shield = r.shield;
          table_mem[i].flags = r.flags;
          table_mem[i].last_seen = r.now;
          o.status = kta_pkg::ST_UPDATED;
          o.slot = i[5:0];
        end else if (table_fill >= kta_pkg::DEPTH) begin
          o.status = kta_pkg::ST_FULL;
        end else begin
          i = table_fill;
          table_mem[i] = '{r.key, r.kind, r.position, r.health, r.shield,
                           r.flags, r.now, r.now};
          table_fill++;
          o.status = kta_pkg::ST_INSERTED;
          o.slot = i[5:0];
        end
      end
      kta_pkg::MODE_PRUNE: begin
        i = 0;
        while (i < table_fill) begin
          deadline = {1'b0, table_mem[i].last_seen} + {1'b0, stale_limit};
          if (deadline < {1'b0, r.now}) begin
            table_mem[i] = table_mem[table_fill - 1];
            table_fill--;
            o.removed_count++;
          end else begin
            i++;
          end
        end
        o.status = kta_pkg::ST_PRUNED;
      end
      kta_pkg::MODE_READ: begin
        o.slot = r.slot_index;
        if (r.slot_index < table_fill) begin
          o.status = kta_pkg::ST_READ_OK;
          o.out_key = table_mem[r.slot_index].key;
          o.out_kind = table_mem[r.slot_index].kind;
          o.out_position = table_mem[r.slot_index].position;
          o.out_health = table_mem[r.slot_index].health;
          o.out_shield = table_mem[r.slot_index].shield;
          o.out_flags = table_mem[r.slot_index].flags;
          o.first_seen = table_mem[r.slot_index].first_seen;
          o.last_seen = table_mem[r.slot_index].last_seen;
        end else begin
          o.status = kta_pkg::ST_EMPTY;
        end
      end
      default: begin
        table_fill = 0;
        o.status = kta_pkg::ST_CLEARED;
      end
    endcase
    o.entry_count = table_fill[6:0];
    return o;
  endfunction

  // watch the channels
  always @(posedge clk) begin
    kta_pkg::rsp_t exp_rsp;
    if (rst) begin
      table_fill = 0;
      stale_limit <= '0;
      fail_count <= 0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) stale_limit <= cfg_data;
      if (req_valid && req_ready) expected_rsp_q = {expected_rsp_q, table_apply(req_data)};
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response exp none act %h", $time, rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (exp_rsp !== rsp_data) begin
            $display("%0t: response mismatch exp %h act %h", $time, exp_rsp, rsp_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[tb/tb_keyed_table_with_aging.sv]
`default_nettype none
module tb_keyed_table_with_aging;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  bit   calm_stretch;
  logic [63:0] recent_keys [8];

  kta_req_if req_ch ();
  kta_rsp_if rsp_ch ();
  kta_cfg_if cfg_ch ();

  keyed_table_with_aging DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  kta_tb_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .req_data     (req_ch.data),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .rsp_data     (rsp_ch.data),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // response side back-pressure
  initial begin
    rsp_ch.ready = 0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm_stretch || ($urandom_range(99) >= 7);
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // valid stays up between back to back requests unless a random gap drops it (never in a calm stretch)
  task automatic send_request(kta_pkg::req_t r);
    while (!calm_stretch && $urandom_range(99) < 7) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [31:0] v);
    wait_drained();
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  function automatic kta_pkg::req_t rand_request(kta_pkg::mode_t m, logic [31:0] t);
    kta_pkg::req_t r;
    r.mode = m;
    r.key = {$urandom, $urandom};
    if ($urandom_range(3) != 0) r.key = recent_keys[3'($urandom_range(7))];
    r.now = t;
    r.slot_index = 6'($urandom_range(63));
    r.kind = 16'($urandom);
    r.position = $urandom;
    r.health = $urandom;
    r.shield = $urandom;
    r.flags = 2'($urandom_range(3));
    return r;
  endfunction

  initial begin
    kta_pkg::req_t r;
    logic [31:0] tick;
    int          n;
    int          roll;
    calm_stretch = 0;
    req_ch.valid = 0;
    req_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    rst = 1;
    for (n = 0; n < 8; n++) recent_keys[n] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every mode, time going backwards, zero age limit
    r = rand_request(kta_pkg::MODE_READ, 0);
    r.slot_index = 0;
    send_request(r);
    r = rand_request(kta_pkg::MODE_OBSERVE, 32'hFFFF_FFFF);
    r.key = '1; r.kind = '1; r.position = '1; r.health = '1; r.shield = '1; r.flags = '1;
    send_request(r);
    r = rand_request(kta_pkg::MODE_OBSERVE, 0);
    r.key = '0; r.kind = '0; r.position = '0; r.health = '0; r.shield = '0; r.flags = '0;
    send_request(r);
    r.now = 32'd5; r.flags = 2'b01;
    send_request(r);
    r = rand_request(kta_pkg::MODE_OBSERVE, 32'hFFFF_FFFF);
    r.key = '1;
    r.now = 32'd3;
    send_request(r);
    for (n = 0; n < 3; n++) begin
      r = rand_request(kta_pkg::MODE_READ, 0);
      r.slot_index = 6'(n);
      send_request(r);
    end
    r = rand_request(kta_pkg::MODE_READ, 0);
    r.slot_index = 63;
    send_request(r);
    r = rand_request(kta_pkg::MODE_PRUNE, 4);
    send_request(r);
    r = rand_request(kta_pkg::MODE_PRUNE, 32'hFFFF_FFFF);
    send_request(r);
    write_age_limit(32'hFFFF_FFFF);
    for (n = 0; n < 4; n++) send_request(rand_request(kta_pkg::MODE_OBSERVE, 0));
    send_request(rand_request(kta_pkg::MODE_PRUNE, 32'hFFFF_FFFF));
    r = rand_request(kta_pkg::MODE_CLEAR, 0);
    send_request(r);
    r = rand_request(kta_pkg::MODE_READ, 0);
    r.slot_index = 0;
    send_request(r);

    // fill the table past capacity so the full drop shows up
    for (n = 0; n < 70; n++) begin
      r = rand_request(kta_pkg::MODE_OBSERVE, n);
      r.key = {32'hA5A5_0000, n};
      send_request(r);
    end
    send_request(rand_request(kta_pkg::MODE_READ, 0));
    wait_drained();

    // random phases at several age limits
    tick = 1000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_age_limit(0);
        1: write_age_limit(32'd20);
        2: write_age_limit($urandom_range(200));
        3: write_age_limit(32'hFFFF_FFFF);
        default: write_age_limit($urandom);
      endcase
      calm_stretch = (ph == 2);
      for (n = 0; n < 200; n++) begin
        roll = $urandom_range(99);
        tick = tick + $urandom_range(4);
        if ($urandom_range(49) == 0) tick = $urandom;
        if ($urandom_range(15) == 0) recent_keys[3'($urandom_range(7))] = {$urandom, $urandom};
        if (roll < 55) r = rand_request(kta_pkg::MODE_OBSERVE, tick);
        else if (roll < 70) r = rand_request(kta_pkg::MODE_PRUNE, tick);
        else if (roll < 97) begin
          r = rand_request(kta_pkg::MODE_READ, tick);
          if ($urandom_range(1)) r.slot_index = 6'($urandom_range(7));
        end else r = rand_request(kta_pkg::MODE_CLEAR, tick);
        send_request(r);
      end
    end
    calm_stretch = 0;

    // hold off until everything is out, then finish
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
